### sv/rmf_pkg.sv
// Shared types for the RGB median filter.
package rmf_pkg;

   localparam int unsigned CHAN_W = 8;
   localparam int unsigned PIX_W  = 3 * CHAN_W;
   localparam int unsigned ROWS_W = 12;
   localparam int unsigned COLS_W = 11;
   localparam logic [ROWS_W-1:0] ROWS_RESET = 12'd480;
   localparam logic [COLS_W-1:0] COLS_RESET = 11'd640;

   // register indexes of the CSR port
   localparam logic [1:0] CSR_OUTPUT_ROWS    = 2'd0;
   localparam logic [1:0] CSR_OUTPUT_COLUMNS = 2'd1;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   // window transfer from the front end into the queue
   typedef struct packed {
      logic push;
      logic last;
   } push_ctl_type;

endpackage

### sv/rmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rmf_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

### sv/rmf_front.sv
// Front end: position counters, line stores and the sliding window.
module rmf_front #(
   parameter int unsigned WS   = 5,
   parameter int unsigned MAXW = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  rmf_pkg::pixel_type                 pixel_in,
   input  logic [rmf_pkg::ROWS_W-1:0]         cfg_rows,
   input  logic [rmf_pkg::COLS_W-1:0]         cfg_cols,
   output logic                               busy,
   output rmf_pkg::push_ctl_type              push_ctl,
   output logic [WS*WS*rmf_pkg::PIX_W-1:0]    window
);
   localparam int unsigned LINES = WS - 1;
   localparam int unsigned AW    = $clog2(MAXW);
   localparam int unsigned CMPW  = (AW + 1 > 12) ? AW + 1 : 12;
   localparam int unsigned PW    = rmf_pkg::PIX_W;
   localparam logic [CMPW-1:0] COL_MAX = CMPW'(MAXW - LINES);
   localparam logic [12:0] ROW_MAX = 13'(4095 - LINES);

   logic [AW-1:0] col_ff, col_in;
   logic [11:0]   row_ff, row_in;
   logic          s1_valid_ff;
   logic          s1_out_ff, s1_last_ff;
   logic [AW-1:0] s1_addr_ff;
   rmf_pkg::pixel_type s1_pix_ff;
   logic [PW-1:0] rd_data [LINES];
   logic [PW-1:0] column [WS];
   logic [PW-1:0] win_ff [WS][WS];
   logic [PW-1:0] win_in [WS][WS];
   logic [CMPW-1:0] cols_sat, pad_w, col_next;
   logic [12:0]   rows_sat, pad_h, row_next;
   logic          row_end, frame_end, produce;

   always_comb begin
      cols_sat  = (CMPW'(cfg_cols) > COL_MAX) ? COL_MAX : CMPW'(cfg_cols);
      rows_sat  = (13'(cfg_rows) > ROW_MAX) ? ROW_MAX : 13'(cfg_rows);
      pad_w     = cols_sat + CMPW'(LINES);
      pad_h     = rows_sat + 13'(LINES);
      col_next  = CMPW'(col_ff) + CMPW'(1);
      row_next  = 13'(row_ff) + 13'd1;
      row_end   = col_next >= pad_w;
      frame_end = row_end && (row_next >= pad_h);
      produce   = (CMPW'(col_ff) >= CMPW'(LINES)) && (row_ff >= 12'(LINES));
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? 12'd0 : row_next[11:0];
         end else begin
            col_in = col_next[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_out_ff  <= produce;
         s1_last_ff <= frame_end;
         s1_addr_ff <= col_ff;
         s1_pix_ff  <= pixel_in;
      end
   end

   // column: oldest line first, incoming pixel last
   always_comb begin
      for (int k = 0; k < LINES; k++) begin
         column[k] = rd_data[k];
      end
      column[LINES] = s1_pix_ff;
      for (int y = 0; y < WS; y++) begin
         for (int x = 0; x < WS - 1; x++) begin
            win_in[y][x] = win_ff[y][x+1];
         end
         win_in[y][WS-1] = column[y];
      end
      for (int t = 0; t < WS * WS; t++) begin
         window[t*PW +: PW] = win_in[t / WS][t % WS];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_ff <= win_in;
      end
   end

   for (genvar k = 0; k < LINES; k++) begin : g_line
      rmf_ram #(.WIDTH(PW), .DEPTH(MAXW)) u_line (
         .clock   (clock),
         .wr_en   (s1_valid_ff),
         .wr_addr (s1_addr_ff),
         .wr_data (column[k+1]),
         .rd_en   (accept),
         .rd_addr (col_ff),
         .rd_data (rd_data[k])
      );
   end

   assign busy          = s1_valid_ff;
   assign push_ctl.push = s1_valid_ff && s1_out_ff;
   assign push_ctl.last = s1_last_ff;
endmodule

### sv/rmf_queue.sv
// Short window queue between the front end and the median pipeline.
module rmf_queue #(
   parameter int unsigned WIDTH = 600,
   parameter int unsigned DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rmf_pkg::push_ctl_type      push_ctl,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic                       pop_valid,
   output logic                       pop_last,
   output logic [WIDTH-1:0]           pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int unsigned PTRW = $clog2(DEPTH);
   localparam int unsigned CNTW = $clog2(DEPTH + 1);

   logic [WIDTH:0]    mem_ff [DEPTH];
   logic [PTRW-1:0]   wptr_ff, rptr_ff;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   logic              do_pop;

   assign do_pop = pop && (cnt_ff != '0);

   always_comb begin
      cnt_in = cnt_ff;
      if (push_ctl.push && !do_pop) begin
         cnt_in = cnt_ff + CNTW'(1);
      end else if (!push_ctl.push && do_pop) begin
         cnt_in = cnt_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push_ctl.push) begin
            wptr_ff <= (wptr_ff == PTRW'(DEPTH - 1)) ? '0 : wptr_ff + PTRW'(1);
         end
         if (do_pop) begin
            rptr_ff <= (rptr_ff == PTRW'(DEPTH - 1)) ? '0 : rptr_ff + PTRW'(1);
         end
      end
      if (push_ctl.push) begin
         mem_ff[wptr_ff] <= {push_ctl.last, push_data};
      end
   end

   assign pop_valid = cnt_ff != '0;
   assign pop_last  = mem_ff[rptr_ff][WIDTH];
   assign pop_data  = mem_ff[rptr_ff][WIDTH-1:0];
   assign count     = cnt_ff;
endmodule

### sv/rmf_back.sv
// Median pipeline: rank by pairwise compare, pick rank TAPS/2, output register.
module rmf_back #(
   parameter int unsigned WS = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic                            in_last,
   input  logic [WS*WS*rmf_pkg::PIX_W-1:0] in_data,
   output logic                            pop,
   output logic                            out_valid,
   input  logic                            out_ready,
   output rmf_pkg::pixel_type              out_pixel,
   output logic                            out_last
);
   localparam int unsigned TAPS = WS * WS;
   localparam int unsigned MID  = TAPS / 2;
   localparam int unsigned CW   = rmf_pkg::CHAN_W;
   localparam int unsigned PW   = rmf_pkg::PIX_W;

   logic          en;
   logic          a_valid_ff, a_last_ff, b_valid_ff, b_last_ff, o_valid_ff;
   logic [CW-1:0] samp [3][TAPS];
   logic [CW-1:0] a_samp_ff [3][TAPS];
   logic [CW-1:0] b_samp_ff [3][TAPS];
   logic [TAPS-1:0] lt_in [3][TAPS];
   logic [TAPS-1:0] a_lt_ff [3][TAPS];
   logic [TAPS-1:0] sel_in [3];
   logic [TAPS-1:0] b_sel_ff [3];
   logic [CW-1:0] med [3];
   rmf_pkg::pixel_type o_pix_ff;
   logic          o_last_ff;

   assign en  = !o_valid_ff || out_ready;
   assign pop = en && in_valid;

   // ties broken by tap index so exactly one sample has each rank
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < TAPS; i++) begin
            samp[c][i] = in_data[i*PW + c*CW +: CW];
         end
      end
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < TAPS; i++) begin
            for (int j = 0; j < TAPS; j++) begin
               if (j < i) begin
                  lt_in[c][i][j] = samp[c][j] <= samp[c][i];
               end else begin
                  lt_in[c][i][j] = samp[c][j] < samp[c][i];
               end
            end
         end
      end
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < TAPS; i++) begin
            sel_in[c][i] = $countones(a_lt_ff[c][i]) == MID;
         end
      end
      for (int c = 0; c < 3; c++) begin
         med[c] = '0;
         for (int i = 0; i < TAPS; i++) begin
            med[c] = med[c] | (b_samp_ff[c][i] & {CW{b_sel_ff[c][i]}});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         o_valid_ff <= b_valid_ff;
      end
      if (en) begin
         a_last_ff      <= in_last;
         a_samp_ff      <= samp;
         a_lt_ff        <= lt_in;
         b_last_ff      <= a_last_ff;
         b_samp_ff      <= a_samp_ff;
         b_sel_ff       <= sel_in;
         o_last_ff      <= b_last_ff;
         o_pix_ff.red   <= med[0];
         o_pix_ff.green <= med[1];
         o_pix_ff.blue  <= med[2];
      end
   end

   assign out_valid = o_valid_ff;
   assign out_pixel = o_pix_ff;
   assign out_last  = o_last_ff;
endmodule

### sv/rgb_median_filter_5x5_unit.sv
// Top level of the streaming RGB median filter.
//
// Input: padded RGB frame, (rows+4) x (columns+4) pixels in raster order, one
// transfer per pixel on req_*. Output: one median pixel per window on rsp_*,
// rows x columns per frame, rsp_frame_last high on the final one.
// Configuration: csr_index 0 = output rows, 1 = output columns; always ready,
// write only while the stream is idle.
// Throughput: one pixel per cycle while req_ready is high. Each pixel passes the
// line store read, then the window update; a finished window passes a 4-entry
// queue and a 3-stage median pipeline (compare, rank, select/output reg).
// No result appears until four padded rows and four padded columns of the
// current row have arrived.
// When rsp_ready is low the median pipeline holds and the queue fills;
// req_ready drops once the queue plus the in-flight pixel would fill it.
// Reset clears counters, queue and pipeline and restores 480 x 640; line
// store contents are left as they are and are only read after being written.
module rgb_median_filter_5x5_unit #(
   parameter int unsigned WINDOW_SIZE      = 5,
   parameter int unsigned MAX_PADDED_WIDTH = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_red_in,
   input  logic [7:0]                     req_green_in,
   input  logic [7:0]                     req_blue_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_red_out,
   output logic [7:0]                     rsp_green_out,
   output logic [7:0]                     rsp_blue_out,
   output logic                           rsp_frame_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [11:0]                    csr_data
);
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QCW    = $clog2(QDEPTH + 1);
   localparam int unsigned WINW   = WINDOW_SIZE * WINDOW_SIZE * rmf_pkg::PIX_W;

   logic [rmf_pkg::ROWS_W-1:0] rows_ff;
   logic [rmf_pkg::COLS_W-1:0] cols_ff;
   logic                       accept, front_busy, pop, q_valid, q_last;
   rmf_pkg::push_ctl_type      push_ctl;
   rmf_pkg::pixel_type         pix_in, pix_out;
   logic [WINW-1:0]            window, q_data;
   logic [QCW-1:0]             q_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= rmf_pkg::ROWS_RESET;
         cols_ff <= rmf_pkg::COLS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            rmf_pkg::CSR_OUTPUT_ROWS:    rows_ff <= csr_data;
            rmf_pkg::CSR_OUTPUT_COLUMNS: cols_ff <= csr_data[rmf_pkg::COLS_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = (QCW'(q_count) + QCW'(front_busy)) < QCW'(QDEPTH);
   assign accept    = req_valid && req_ready;
   assign pix_in    = '{blue: req_blue_in, green: req_green_in, red: req_red_in};

   rmf_front #(.WS(WINDOW_SIZE), .MAXW(MAX_PADDED_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .pixel_in (pix_in),
      .cfg_rows (rows_ff),
      .cfg_cols (cols_ff),
      .busy     (front_busy),
      .push_ctl (push_ctl),
      .window   (window)
   );

   rmf_queue #(.WIDTH(WINW), .DEPTH(QDEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_ctl  (push_ctl),
      .push_data (window),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_last  (q_last),
      .pop_data  (q_data),
      .count     (q_count)
   );

   rmf_back #(.WS(WINDOW_SIZE)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_last   (q_last),
      .in_data   (q_data),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_pixel (pix_out),
      .out_last  (rsp_frame_last)
   );

   assign rsp_red_out   = pix_out.red;
   assign rsp_green_out = pix_out.green;
   assign rsp_blue_out  = pix_out.blue;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QCW'(QDEPTH))
      else $error("window queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_ctl.push && !pop && q_count == QCW'(QDEPTH)))
      else $error("window pushed into full queue");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
endmodule

### bench/tb_top.sv
// Self-checking bench for the streaming RGB 5x5 median filter.
`timescale 1ns / 100ps

module tb_top;

   localparam int LINE_W = 2048;

   typedef enum int {
      FILL_RANDOM,
      FILL_MAX,
      FILL_ZERO,
      FILL_ALT
   } fill_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_red_in = 8'd0, req_green_in = 8'd0, req_blue_in = 8'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic rsp_frame_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = rmf_pkg::CSR_OUTPUT_ROWS;
   logic [11:0] csr_data = 12'd0;

   rgb_median_filter_5x5_unit dut (.*);

   always #6 clock = ~clock;

   typedef struct packed {
      rmf_pkg::pixel_type px;
      logic               last;
   } median_type;

   rmf_pkg::pixel_type pixel_q[$];
   median_type median_q[$];
   int errors = 0;
   int medians_seen = 0;
   bit stall_hold = 1'b0;
   bit stall_go = 1'b0;
   bit stall_done = 1'b0;
   bit in_taken = 1'b0;

   // predictor state
   rmf_pkg::pixel_type lines[4][LINE_W];
   rmf_pkg::pixel_type win[5][5];
   int unsigned col_pos, row_pos, cfg_rows, cfg_cols;

   function automatic logic [7:0] chan_median(int sh);
      logic [7:0] v[25];
      logic [7:0] t;
      int n = 0;
      for (int y = 0; y < 5; y++)
         for (int x = 0; x < 5; x++) begin
            v[n] = 8'(win[y][x] >> sh);
            n++;
         end
      for (int i = 1; i < 25; i++)
         for (int k = i; k > 0 && v[k-1] > v[k]; k--) begin
            t = v[k]; v[k] = v[k-1]; v[k-1] = t;
         end
      return v[12];
   endfunction

   task automatic predict_pixel(rmf_pkg::pixel_type p);
      rmf_pkg::pixel_type colv[5];
      int unsigned cols, rows, ci;
      bit row_end, frame_end;
      median_type m;
      cols = (cfg_cols > 2044) ? 2044 : cfg_cols;
      rows = (cfg_rows > 4091) ? 4091 : cfg_rows;
      ci = (col_pos < LINE_W) ? col_pos : LINE_W - 1;
      for (int k = 0; k < 4; k++) colv[k] = lines[k][ci];
      colv[4] = p;
      for (int k = 0; k < 4; k++) lines[k][ci] = colv[k+1];
      for (int y = 0; y < 5; y++) begin
         for (int x = 0; x < 4; x++) win[y][x] = win[y][x+1];
         win[y][4] = colv[y];
      end
      row_end = (col_pos + 1 >= cols + 4);
      frame_end = row_end && (row_pos + 1 >= rows + 4);
      if (col_pos >= 4 && row_pos >= 4) begin
         m.px.red = chan_median(0);
         m.px.green = chan_median(8);
         m.px.blue = chan_median(16);
         m.last = frame_end;
         median_q.push_back(m);
      end
      if (row_end) begin
         col_pos = 0;
         row_pos = frame_end ? 0 : row_pos + 1;
      end else
         col_pos++;
   endtask

   // input transfers are taken at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_pixel(pixel_q.pop_front());
         in_taken = 1'b1;
      end
   end

   // driver
   int gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !in_taken) begin
            // hold payload
         end else if (gap > 0) begin
            in_taken = 1'b0;
            gap--;
            req_valid <= 1'b0;
         end else if (pixel_q.size() > 0) begin
            in_taken = 1'b0;
            req_valid <= 1'b1;
            req_red_in <= pixel_q[0].red;
            req_green_in <= pixel_q[0].green;
            req_blue_in <= pixel_q[0].blue;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) :
                  ($urandom_range(0, 60) == 0) ? $urandom_range(10, 40) : 0;
         end else begin
            in_taken = 1'b0;
            req_valid <= 1'b0;
         end
         rsp_ready <= stall_hold ? 1'b0 : ($urandom_range(0, 7) != 0 ||
                      $urandom_range(0, 40) == 0);
      end
   end

   // long receiver hold-off, counted here
   initial begin
      wait (stall_go);
      stall_hold = 1'b1;
      repeat (200) @(posedge clock);
      stall_hold = 1'b0;
      stall_done = 1'b1;
   end

   // monitor
   always @(posedge clock) begin
      median_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         medians_seen++;
         if (median_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result %h %h %h last %b", $time, rsp_red_out,
                     rsp_green_out, rsp_blue_out, rsp_frame_last);
         end else begin
            e = median_q.pop_front();
            if (rsp_red_out !== e.px.red || rsp_green_out !== e.px.green ||
                rsp_blue_out !== e.px.blue || rsp_frame_last !== e.last) begin
               errors++;
               $display("%0t mismatch: expected r%h g%h b%h last %b, actual r%h g%h b%h last %b",
                        $time, e.px.red, e.px.green, e.px.blue, e.last, rsp_red_out,
                        rsp_green_out, rsp_blue_out, rsp_frame_last);
            end
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [11:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == rmf_pkg::CSR_OUTPUT_ROWS) cfg_rows = val;
      else cfg_cols = val[10:0];
   endtask

   task automatic drain;
      while (pixel_q.size() > 0 || req_valid || median_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // queues frames of padded pixels
   task automatic add_frames(int nframes, fill_type mode);
      rmf_pkg::pixel_type p;
      int unsigned rows, cols;
      rows = (cfg_rows > 4091) ? 4091 : cfg_rows;
      cols = (cfg_cols > 2044) ? 2044 : cfg_cols;
      for (int f = 0; f < nframes; f++)
         for (int i = 0; i < (rows + 4) * (cols + 4); i++) begin
            case (mode)
               FILL_MAX:  p = '1;
               FILL_ZERO: p = '0;
               FILL_ALT:  p = (i % 2) ? '1 : '0;
               default:   p = 24'($urandom());
            endcase
            pixel_q.push_back(p);
         end
   endtask

   task automatic run_setting(logic [11:0] rows, logic [11:0] cols, int nframes,
                              fill_type mode);
      csr_write(rmf_pkg::CSR_OUTPUT_ROWS, rows);
      csr_write(rmf_pkg::CSR_OUTPUT_COLUMNS, cols);
      add_frames(nframes, mode);
      drain();
   endtask

   initial begin
      cfg_rows = rmf_pkg::ROWS_RESET;
      cfg_cols = rmf_pkg::COLS_RESET;
      col_pos = 0;
      row_pos = 0;
      foreach (win[y, x]) win[y][x] = '0;
      foreach (lines[k, i]) lines[k][i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: extremes, minimum sizes, zero sizes
      run_setting(12'd1, 12'd1, 1, FILL_MAX);
      run_setting(12'd1, 12'd1, 1, FILL_ZERO);
      run_setting(12'd1, 12'd2, 1, FILL_ALT);
      run_setting(12'd0, 12'd3, 1, FILL_RANDOM);
      run_setting(12'd2, 12'd0, 1, FILL_RANDOM);
      // back pressure: hold off receiver while sender keeps going
      csr_write(rmf_pkg::CSR_OUTPUT_ROWS, 12'd3);
      csr_write(rmf_pkg::CSR_OUTPUT_COLUMNS, 12'd6);
      add_frames(2, FILL_RANDOM);
      stall_go = 1'b1;
      wait (stall_done);
      drain();
      // random sizes, mostly small
      for (int s = 0; s < 10; s++)
         run_setting(12'($urandom_range(1, 6)), 12'($urandom_range(1, 8)),
                     $urandom_range(1, 2), FILL_RANDOM);
      $display("Covered %0d medians over minimum, zero and random small frame sizes,",
               medians_seen);
      $display("with random gaps on both sides and one long receiver stall.");
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #300ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
